// ===== design/assert_macros.svh =====
// Assertion macros of the estimator RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, off while reset is low.
`define TMRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked property, also during reset.
`define TMRE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TMRE_ASSERT(lbl, prop, msg)
`define TMRE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/tmre_pkg.sv =====
// Shared constants, types and codes of the thrust model RLS estimator.
// No dependencies.
`default_nettype none
package tmre_pkg;

  localparam int unsigned QUEUE_DEPTH = 100;
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] MAX_AGE_US = 32'd45000;
  localparam logic [31:0] MIN_AGE_US = 32'd35000;

  localparam logic [47:0] COV_INIT = 48'd16777216000000;
  localparam logic [63:0] COV_MAX  = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] K_CAP    = 64'h4000_0000_0000_0000;
  localparam logic [63:0] THR_CAP  = 64'h0000_0000_8000_0000;
  localparam logic [63:0] GAIN_CAP = 64'h0000_0000_7FFF_FFFF;
  localparam logic [33:0] DMAG_CAP = 34'h2_0000_0000;

  localparam logic [30:0] GRAVITY_RST = 31'd642689;
  localparam logic [16:0] HOVER_RST   = 17'd19661;
  localparam logic [16:0] FF_RST      = 17'd65405;

  localparam logic [1:0] CFG_GRAVITY = 2'd0;
  localparam logic [1:0] CFG_HOVER   = 2'd1;
  localparam logic [1:0] CFG_FORGET  = 2'd2;

  localparam logic [1:0] FUNC_CMD    = 2'd0;
  localparam logic [1:0] FUNC_MEAS   = 2'd1;
  localparam logic [1:0] FUNC_REINIT = 2'd2;

  typedef enum logic [4:0] {
    ST_INIT, ST_INIT_WAIT, ST_IDLE, ST_DISPATCH, ST_REINIT_WAIT, ST_CMD_WAIT, ST_ENQ,
    ST_MEAS_CHK, ST_MEAS_AGE, ST_SQ_WAIT, ST_TERM_WAIT, ST_KNUM_WAIT, ST_KDIV_WAIT,
    ST_PDIV_WAIT, ST_EMUL_WAIT, ST_KE, ST_KE_WAIT, ST_RESP
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_REINIT_GO, OP_REINIT_SET, OP_CMD_GO, OP_CMD_SET, OP_ENQUEUE,
    OP_DROP, OP_TAKE, OP_TERM_GO, OP_DEN_KNUM, OP_KDIV_GO, OP_PDIV_GO, OP_EMUL_GO,
    OP_ERR_SET, OP_KE_GO, OP_GAIN_SET, OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       mul_busy;
    logic       div_busy;
    logic       queue_empty;
    logic       age_stale;
    logic       age_fresh;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== design/tmre_ifs.sv =====
// Valid/ready channel interfaces of the estimator: item in, result out, config write.
// No dependencies.
`default_nettype none
interface tmre_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] accel_z;
  logic [31:0] time_us;
  modport source (output valid, func, accel_z, time_us, input ready);
  modport sink (input valid, func, accel_z, time_us, output ready);
endinterface

interface tmre_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] throttle;
  logic        model_updated;
  logic [31:0] accel_per_throttle;
  modport source (output valid, throttle, model_updated, accel_per_throttle, input ready);
  modport sink (input valid, throttle, model_updated, accel_per_throttle, output ready);
endinterface

interface tmre_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/thrust_model_rls_estimator_top.sv =====
// Top level of the thrust model RLS estimator: sequencer plus datapath.
// Depends on tmre_pkg, tmre_ifs, tmre_ctrl, tmre_dp.
//
// Usage:
//  in_chan_i takes one word per item: func (0 command, 1 measurement, 2 reinit),
//  accel_z and time_us. out_chan_o returns one word per item: throttle,
//  model_updated and the gain estimate after the item. cfg_chan_i writes
//  gravity (0), hover_throttle (1) and forgetting_factor (2); it is always ready.
//  One item is in flight at a time; in_chan_i.ready is high only when idle.
//  The time from accept to result valid is set by the shared bit-serial
//  multiplier and divider and the queue memory read: a command or reinit
//  waits on a divider pass, an unused func goes straight to the result, and
//  a measurement checks the age of each head entry in turn, dropping stale
//  ones, and runs multiplier and divider passes when an entry feeds an update.
//  Reset clears the queue, loads the register defaults and covariance, then
//  divides gravity by hover throttle for the gain (no item taken).
//  The result sits in an output register; a stalled receiver holds it there
//  and the block stalls only before loading the next result.
`default_nettype none
module thrust_model_rls_estimator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  tmre_in_if.sink    in_chan_i,
  tmre_out_if.source out_chan_o,
  tmre_cfg_if.sink   cfg_chan_i
);

  tmre_pkg::dp_cmd_t    cmd;
  tmre_pkg::dp_status_t st;

  assign cfg_chan_i.ready = 1'b1;

  tmre_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_chan_i.valid),
    .in_ready_o (in_chan_i.ready),
    .out_valid_o(out_chan_o.valid),
    .out_ready_i(out_chan_o.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  tmre_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i               (cmd),
    .st_o                (st),
    .cfg_valid_i         (cfg_chan_i.valid),
    .cfg_index_i         (cfg_chan_i.index),
    .cfg_data_i          (cfg_chan_i.data),
    .func_i              (in_chan_i.func),
    .accel_z_i           (in_chan_i.accel_z),
    .time_us_i           (in_chan_i.time_us),
    .throttle_o          (out_chan_o.throttle),
    .model_updated_o     (out_chan_o.model_updated),
    .accel_per_throttle_o(out_chan_o.accel_per_throttle)
  );

endmodule
`default_nettype wire

// ===== design/tmre_mul.sv =====
// Shift-add 64 x 64 unsigned multiplier, one multiplier bit per cycle.
// No dependencies.
`default_nettype none
module tmre_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         busy_o,
  output logic [127:0] prod_o
);

  logic [63:0]  a_q, b_q;
  logic [127:0] acc_q;
  logic [6:0]   cnt_q;
  logic         busy_q;
  logic [64:0]  sum;

  assign sum = {1'b0, acc_q[127:64]} + {1'b0, (b_q[0] ? a_q : 64'd0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd64;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= {sum, acc_q[63:1]};
      b_q   <= {1'b0, b_q[63:1]};
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

// ===== design/tmre_div.sv =====
// Restoring divider: 128-bit numerator over 64-bit divisor, one quotient bit per cycle,
// quotient saturated at a given cap. No dependencies.
`default_nettype none
module tmre_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_hi_i,
  input  logic [63:0] num_lo_i,
  input  logic [63:0] den_i,
  input  logic [63:0] cap_i,
  output logic        busy_o,
  output logic [63:0] quo_o
);

  logic [63:0] rem_q, lo_q, quo_q, den_q, cap_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [63:0] shifted;
  logic        take;
  logic        overflow;

  assign overflow = (num_hi_i >= den_i);
  assign shifted  = {rem_q[62:0], lo_q[63]};
  assign take     = rem_q[63] | (shifted >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else if (start_i) begin
      busy_q <= ~overflow;
      cnt_q  <= 7'd64;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_hi_i;
      lo_q  <= num_lo_i;
      den_q <= den_i;
      cap_q <= cap_i;
      // quotient would not fit: saturate right away
      quo_q <= overflow ? cap_i : 64'd0;
    end else if (busy_q) begin
      rem_q <= take ? shifted - den_q : shifted;
      lo_q  <= {lo_q[62:0], 1'b0};
      quo_q <= {quo_q[62:0], take};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = (quo_q > cap_q) ? cap_q : quo_q;

endmodule
`default_nettype wire

// ===== design/tmre_ctrl.sv =====
// Sequencer of the estimator: walks each item through the datapath operations.
// Depends on tmre_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module tmre_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  tmre_pkg::dp_status_t st_i,
  output tmre_pkg::dp_cmd_t    cmd_o
);

  tmre_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tmre_pkg::ST_INIT:      state_d = tmre_pkg::ST_INIT_WAIT;
      tmre_pkg::ST_INIT_WAIT: if (!st_i.div_busy) state_d = tmre_pkg::ST_IDLE;
      tmre_pkg::ST_IDLE:      if (in_valid_i) state_d = tmre_pkg::ST_DISPATCH;
      tmre_pkg::ST_DISPATCH: begin
        unique case (st_i.func)
          tmre_pkg::FUNC_CMD:    state_d = tmre_pkg::ST_CMD_WAIT;
          tmre_pkg::FUNC_MEAS:   state_d = tmre_pkg::ST_MEAS_CHK;
          tmre_pkg::FUNC_REINIT: state_d = tmre_pkg::ST_REINIT_WAIT;
          default:               state_d = tmre_pkg::ST_RESP;
        endcase
      end
      tmre_pkg::ST_REINIT_WAIT: if (!st_i.div_busy) state_d = tmre_pkg::ST_RESP;
      tmre_pkg::ST_CMD_WAIT:    if (!st_i.div_busy) state_d = tmre_pkg::ST_ENQ;
      tmre_pkg::ST_ENQ:         state_d = tmre_pkg::ST_RESP;
      tmre_pkg::ST_MEAS_CHK: begin
        state_d = st_i.queue_empty ? tmre_pkg::ST_RESP : tmre_pkg::ST_MEAS_AGE;
      end
      tmre_pkg::ST_MEAS_AGE: begin
        if (st_i.age_stale)      state_d = tmre_pkg::ST_MEAS_CHK;
        else if (st_i.age_fresh) state_d = tmre_pkg::ST_RESP;
        else                     state_d = tmre_pkg::ST_SQ_WAIT;
      end
      tmre_pkg::ST_SQ_WAIT:   if (!st_i.mul_busy) state_d = tmre_pkg::ST_TERM_WAIT;
      tmre_pkg::ST_TERM_WAIT: if (!st_i.mul_busy) state_d = tmre_pkg::ST_KNUM_WAIT;
      tmre_pkg::ST_KNUM_WAIT: if (!st_i.mul_busy) state_d = tmre_pkg::ST_KDIV_WAIT;
      tmre_pkg::ST_KDIV_WAIT: if (!st_i.div_busy) state_d = tmre_pkg::ST_PDIV_WAIT;
      tmre_pkg::ST_PDIV_WAIT: if (!st_i.div_busy) state_d = tmre_pkg::ST_EMUL_WAIT;
      tmre_pkg::ST_EMUL_WAIT: if (!st_i.mul_busy) state_d = tmre_pkg::ST_KE;
      tmre_pkg::ST_KE:        state_d = tmre_pkg::ST_KE_WAIT;
      tmre_pkg::ST_KE_WAIT:   if (!st_i.mul_busy) state_d = tmre_pkg::ST_RESP;
      tmre_pkg::ST_RESP:      if (out_free) state_d = tmre_pkg::ST_IDLE;
      default:                state_d = tmre_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o.op    = tmre_pkg::OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      tmre_pkg::ST_INIT: cmd_o.op = tmre_pkg::OP_REINIT_GO;
      tmre_pkg::ST_INIT_WAIT: begin
        if (!st_i.div_busy) cmd_o.op = tmre_pkg::OP_REINIT_SET;
      end
      tmre_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = tmre_pkg::OP_CAPTURE;
      end
      tmre_pkg::ST_DISPATCH: begin
        if (st_i.func == tmre_pkg::FUNC_CMD)         cmd_o.op = tmre_pkg::OP_CMD_GO;
        else if (st_i.func == tmre_pkg::FUNC_REINIT) cmd_o.op = tmre_pkg::OP_REINIT_GO;
      end
      tmre_pkg::ST_REINIT_WAIT: begin
        if (!st_i.div_busy) cmd_o.op = tmre_pkg::OP_REINIT_SET;
      end
      tmre_pkg::ST_CMD_WAIT: if (!st_i.div_busy) cmd_o.op = tmre_pkg::OP_CMD_SET;
      tmre_pkg::ST_ENQ:      cmd_o.op = tmre_pkg::OP_ENQUEUE;
      tmre_pkg::ST_MEAS_CHK: cmd_o.op = tmre_pkg::OP_NONE;
      tmre_pkg::ST_MEAS_AGE: begin
        if (st_i.age_stale)       cmd_o.op = tmre_pkg::OP_DROP;
        else if (!st_i.age_fresh) cmd_o.op = tmre_pkg::OP_TAKE;
      end
      tmre_pkg::ST_SQ_WAIT:   if (!st_i.mul_busy) cmd_o.op = tmre_pkg::OP_TERM_GO;
      tmre_pkg::ST_TERM_WAIT: if (!st_i.mul_busy) cmd_o.op = tmre_pkg::OP_DEN_KNUM;
      tmre_pkg::ST_KNUM_WAIT: if (!st_i.mul_busy) cmd_o.op = tmre_pkg::OP_KDIV_GO;
      tmre_pkg::ST_KDIV_WAIT: if (!st_i.div_busy) cmd_o.op = tmre_pkg::OP_PDIV_GO;
      tmre_pkg::ST_PDIV_WAIT: if (!st_i.div_busy) cmd_o.op = tmre_pkg::OP_EMUL_GO;
      tmre_pkg::ST_EMUL_WAIT: if (!st_i.mul_busy) cmd_o.op = tmre_pkg::OP_ERR_SET;
      tmre_pkg::ST_KE:        cmd_o.op = tmre_pkg::OP_KE_GO;
      tmre_pkg::ST_KE_WAIT:   if (!st_i.mul_busy) cmd_o.op = tmre_pkg::OP_GAIN_SET;
      tmre_pkg::ST_RESP: begin
        if (out_free) begin
          cmd_o.op    = tmre_pkg::OP_RESULT;
          out_valid_d = 1'b1;
        end
      end
      default: cmd_o.op = tmre_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tmre_pkg::ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `TMRE_ASSERT(a_accept_dispatch, (in_valid_i && in_ready_o) |=> (state_q == tmre_pkg::ST_DISPATCH), "accepted word not dispatched")
  `TMRE_ASSERT(a_result_loaded, (cmd_o.op == tmre_pkg::OP_RESULT) |=> out_valid_q, "result word lost")
  `TMRE_ASSERT_ALWAYS(a_units_exclusive, !(st_i.mul_busy && st_i.div_busy), "multiplier and divider overlap")

endmodule
`default_nettype wire

// ===== design/tmre_dp.sv =====
// Datapath: config registers, sample queue memory, gain/covariance state and the
// shared multiplier and divider. Depends on tmre_pkg, tmre_mul, tmre_div.
`default_nettype none
module tmre_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tmre_pkg::dp_cmd_t    cmd_i,
  output tmre_pkg::dp_status_t st_o,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic [1:0]           func_i,
  input  logic [31:0]          accel_z_i,
  input  logic [31:0]          time_us_i,
  output logic [31:0]          throttle_o,
  output logic                 model_updated_o,
  output logic [31:0]          accel_per_throttle_o
);

  localparam int unsigned IW = tmre_pkg::IDX_W;
  localparam int unsigned CW = tmre_pkg::CNT_W;

  // config
  logic [30:0] grav_q;
  logic [16:0] hover_q, ff_q;

  // item
  logic [1:0]  func_q;
  logic [31:0] accel_q, time_q;

  // estimator state
  logic signed [31:0] gain_q;
  logic [47:0]        cov_q;
  logic [IW-1:0]      head_q;
  logic [CW-1:0]      count_q;

  // working registers
  logic [31:0] thr_q, sthr_q;
  logic        upd_q;
  logic [63:0] den_q, kmag_q, emag_q;
  logic [47:0] pnew_q;
  logic        eneg_q;
  logic [31:0] out_thr_q, out_gain_q;
  logic        out_upd_q;

  // queue memory: {stamp, throttle}
  logic [63:0]   q_mem [tmre_pkg::QUEUE_DEPTH];
  logic [63:0]   rd_q;
  logic          wr_en;
  logic [IW-1:0] slot;

  // units
  logic         mul_start, mul_busy;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] prod;
  logic         div_start, div_busy;
  logic [63:0]  div_hi, div_lo, div_den, div_cap, quo;

  tmre_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .busy_o(mul_busy), .prod_o(prod)
  );

  tmre_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_hi_i(div_hi), .num_lo_i(div_lo),
    .den_i(div_den), .cap_i(div_cap), .busy_o(div_busy), .quo_o(quo)
  );

  // magnitudes and signs
  logic [31:0] accel_mag, gain_mag, sthr_mag, rd_thr_mag;
  assign accel_mag  = accel_q[31] ? 32'(-accel_q) : accel_q;
  assign gain_mag   = gain_q[31] ? 32'(-gain_q) : 32'(gain_q);
  assign sthr_mag   = sthr_q[31] ? 32'(-sthr_q) : sthr_q;
  assign rd_thr_mag = rd_q[31] ? 32'(-rd_q[31:0]) : rd_q[31:0];

  // queue bookkeeping
  logic          full;
  logic [IW-1:0] head_inc, head_n;
  logic [CW-1:0] cnt_n;
  logic [CW:0]   slot_sum;
  logic [31:0]   age;

  assign head_inc = (head_q == IW'(tmre_pkg::QUEUE_DEPTH - 1)) ? '0 : head_q + IW'(1);
  assign full     = (count_q >= CW'(tmre_pkg::QUEUE_DEPTH));
  assign head_n   = full ? head_inc : head_q;
  assign cnt_n    = full ? CW'(tmre_pkg::QUEUE_DEPTH - 1) : count_q;
  assign slot_sum = (CW+1)'(head_n) + (CW+1)'(cnt_n);
  assign slot     = (slot_sum >= (CW+1)'(tmre_pkg::QUEUE_DEPTH))
                  ? IW'(slot_sum - (CW+1)'(tmre_pkg::QUEUE_DEPTH)) : IW'(slot_sum);
  assign age      = time_q - rd_q[63:32];
  assign wr_en    = (cmd_i.op == tmre_pkg::OP_ENQUEUE);

  // command throttle from quotient
  logic [32:0] q33;
  logic        cmd_neg;
  logic [31:0] cmd_thr;
  assign q33     = quo[32:0];
  assign cmd_neg = accel_q[31] ^ gain_q[31];
  always_comb begin
    if (accel_q == 32'd0)  cmd_thr = 32'd0;
    else if (cmd_neg)      cmd_thr = 32'(-q33);
    else if (q33[31])      cmd_thr = 32'h7FFF_FFFF;
    else                   cmd_thr = q33[31:0];
  end

  // denominator rho + thr^2 * P
  logic [63:0] term, den_sum, den_val;
  assign term    = ((prod[127:96] != 32'd0) || (prod[95:32] > tmre_pkg::K_CAP))
                 ? tmre_pkg::K_CAP : prod[95:32];
  assign den_sum = {39'd0, ff_q, 8'd0} + term;
  assign den_val = (den_sum == 64'd0) ? 64'd1 : den_sum;

  // prediction error accel - thr * gain, Q32.32
  logic signed [63:0] a_sh, err;
  logic               tg_neg;
  assign a_sh   = {{16{accel_q[31]}}, accel_q, 16'd0};
  assign tg_neg = sthr_q[31] ^ gain_q[31];
  assign err    = tg_neg ? a_sh + $signed(prod[63:0]) : a_sh - $signed(prod[63:0]);

  // gain correction
  logic [33:0]        dmag;
  logic signed [35:0] gsum;
  logic signed [31:0] gain_new;
  assign dmag = ((prod[127:104] != 24'd0) || (prod[103:40] > 64'(tmre_pkg::DMAG_CAP)))
              ? tmre_pkg::DMAG_CAP : prod[73:40];
  assign gsum = eneg_q ? 36'(gain_q) - $signed({2'b00, dmag})
                       : 36'(gain_q) + $signed({2'b00, dmag});
  always_comb begin
    if (gsum > 36'sh0_7FFF_FFFF)       gain_new = 32'sh7FFF_FFFF;
    else if (gsum < -36'sh0_8000_0000) gain_new = 32'sh8000_0000;
    else                               gain_new = gsum[31:0];
  end

  // unit operands
  always_comb begin
    mul_start = 1'b0;
    mul_a     = 64'd0;
    mul_b     = 64'd0;
    div_start = 1'b0;
    div_hi    = 64'd0;
    div_lo    = 64'd0;
    div_den   = 64'd0;
    div_cap   = 64'd0;
    case (cmd_i.op)
      tmre_pkg::OP_REINIT_GO: begin
        div_start = 1'b1;
        div_lo    = {17'd0, grav_q, 16'd0};
        div_den   = {47'd0, hover_q};
        div_cap   = tmre_pkg::GAIN_CAP;
      end
      tmre_pkg::OP_CMD_GO: begin
        div_start = 1'b1;
        div_lo    = {16'd0, accel_mag, 16'd0};
        div_den   = {32'd0, gain_mag};
        div_cap   = tmre_pkg::THR_CAP;
      end
      tmre_pkg::OP_TAKE: begin
        mul_start = 1'b1;
        mul_a     = {32'd0, rd_thr_mag};
        mul_b     = {32'd0, rd_thr_mag};
      end
      tmre_pkg::OP_TERM_GO: begin
        mul_start = 1'b1;
        mul_a     = prod[63:0];
        mul_b     = {16'd0, cov_q};
      end
      tmre_pkg::OP_DEN_KNUM: begin
        mul_start = 1'b1;
        mul_a     = {32'd0, sthr_mag};
        mul_b     = {16'd0, cov_q};
      end
      tmre_pkg::OP_KDIV_GO: begin
        div_start = 1'b1;
        div_hi    = prod[119:56];
        div_lo    = {prod[55:0], 8'd0};
        div_den   = den_q;
        div_cap   = tmre_pkg::K_CAP;
      end
      tmre_pkg::OP_PDIV_GO: begin
        div_start = 1'b1;
        div_hi    = {56'd0, cov_q[47:40]};
        div_lo    = {cov_q[39:0], 24'd0};
        div_den   = den_q;
        div_cap   = tmre_pkg::COV_MAX;
      end
      tmre_pkg::OP_EMUL_GO: begin
        mul_start = 1'b1;
        mul_a     = {32'd0, sthr_mag};
        mul_b     = {32'd0, gain_mag};
      end
      tmre_pkg::OP_KE_GO: begin
        mul_start = 1'b1;
        mul_a     = kmag_q;
        mul_b     = emag_q;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q  <= tmre_pkg::GRAVITY_RST;
      hover_q <= tmre_pkg::HOVER_RST;
      ff_q    <= tmre_pkg::FF_RST;
      head_q  <= '0;
      count_q <= '0;
      gain_q  <= '0;
      cov_q   <= tmre_pkg::COV_INIT;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          tmre_pkg::CFG_GRAVITY: grav_q  <= cfg_data_i[30:0];
          tmre_pkg::CFG_HOVER:   hover_q <= cfg_data_i[16:0];
          tmre_pkg::CFG_FORGET:  ff_q    <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        tmre_pkg::OP_REINIT_SET: begin
          gain_q <= quo[31:0];
          cov_q  <= tmre_pkg::COV_INIT;
        end
        tmre_pkg::OP_ENQUEUE: begin
          head_q  <= head_n;
          count_q <= cnt_n + CW'(1);
        end
        tmre_pkg::OP_DROP, tmre_pkg::OP_TAKE: begin
          head_q  <= head_inc;
          count_q <= count_q - CW'(1);
        end
        tmre_pkg::OP_GAIN_SET: begin
          gain_q <= gain_new;
          cov_q  <= pnew_q;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      tmre_pkg::OP_CAPTURE: begin
        func_q  <= func_i;
        accel_q <= accel_z_i;
        time_q  <= time_us_i;
        thr_q   <= 32'd0;
        upd_q   <= 1'b0;
      end
      tmre_pkg::OP_CMD_SET:  thr_q  <= cmd_thr;
      tmre_pkg::OP_TAKE:     sthr_q <= rd_q[31:0];
      tmre_pkg::OP_DEN_KNUM: den_q  <= den_val;
      tmre_pkg::OP_PDIV_GO:  kmag_q <= quo;
      tmre_pkg::OP_EMUL_GO:  pnew_q <= quo[47:0];
      tmre_pkg::OP_ERR_SET: begin
        emag_q <= err[63] ? 64'(-err) : 64'(err);
        eneg_q <= err[63] ^ sthr_q[31];
      end
      tmre_pkg::OP_GAIN_SET: upd_q <= 1'b1;
      tmre_pkg::OP_RESULT: begin
        out_thr_q  <= thr_q;
        out_upd_q  <= upd_q;
        out_gain_q <= gain_q;
      end
      default: ;
    endcase
  end

  // queue memory, registered read at the head
  always_ff @(posedge clk_i) begin
    if (wr_en) q_mem[slot] <= {time_q, thr_q};
    rd_q <= q_mem[head_q];
  end

  assign st_o.func        = func_q;
  assign st_o.mul_busy    = mul_busy;
  assign st_o.div_busy    = div_busy;
  assign st_o.queue_empty = (count_q == '0);
  assign st_o.age_stale   = (age > tmre_pkg::MAX_AGE_US);
  assign st_o.age_fresh   = (age < tmre_pkg::MIN_AGE_US);

  assign throttle_o           = out_thr_q;
  assign model_updated_o      = out_upd_q;
  assign accel_per_throttle_o = out_gain_q;

endmodule
`default_nettype wire

// ===== test/tb_thrust_model_rls_estimator_top.sv =====
// Self-checking testbench of the thrust model RLS estimator: random and directed items,
// register phases, and a gain/covariance predictor checked against every result word.
// Depends on tmre_pkg, tmre_ifs and the estimator RTL.
`default_nettype none
module tb_thrust_model_rls_estimator_top;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 800;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] accel;
    logic [31:0] stamp;
  } item_t;

  typedef struct packed {
    logic [31:0] throttle;
    logic        updated;
    logic [31:0] gain;
  } result_t;

  logic clk_i;
  logic rst_ni;

  tmre_in_if  in_if ();
  tmre_out_if out_if ();
  tmre_cfg_if cfg_if ();

  thrust_model_rls_estimator_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if.sink),
    .out_chan_o (out_if.source),
    .cfg_chan_i (cfg_if.sink)
  );

  // Estimator state as this testbench tracks it.
  logic [31:0]  hist_time [tmre_pkg::QUEUE_DEPTH];
  logic [31:0]  hist_thr [tmre_pkg::QUEUE_DEPTH];
  int unsigned  hist_head;
  int unsigned  hist_count;
  longint       gain_est;
  logic [63:0]  cov_est;
  logic [63:0]  reg_gravity;
  logic [63:0]  reg_hover;
  logic [63:0]  reg_forget;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      error_count;
  int      results_seen;
  logic [31:0] now_us;
  bit      sender_eager;
  bit      receiver_eager;

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] shift_sat(logic [127:0] w, int n, logic [63:0] cap);
    logic [127:0] s;
    s = w >> n;
    if (s > {64'd0, cap}) return cap;
    return s[63:0];
  endfunction

  function automatic logic [63:0] div_sat(logic [127:0] num, logic [63:0] d, logic [63:0] cap);
    logic [127:0] q;
    if (num[127:64] >= d) return cap;
    q = num / {64'd0, d};
    if (q > {64'd0, cap}) return cap;
    return q[63:0];
  endfunction

  function automatic void reseed_gain();
    logic [63:0] q;
    if (reg_hover == 0) begin
      gain_est = 64'sd2147483647;
    end else begin
      q = (reg_gravity << 16) / reg_hover;
      gain_est = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    end
    cov_est = {16'd0, tmre_pkg::COV_INIT};
  endfunction

  function automatic longint command_throttle(longint a);
    logic [63:0] am, gm, q;
    bit neg;
    if (gain_est == 0) begin
      if (a == 0) return 0;
      return (a > 0) ? 64'sd2147483647 : -64'sd2147483648;
    end
    am = magnitude(a);
    gm = magnitude(gain_est);
    neg = (a < 0) != (gain_est < 0);
    q = (am << 16) / gm;
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return clamp_s32(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic void rls_update(longint thr, longint a);
    logic [63:0]  at, sq, term, d, kmag, pnew, emag, dmag;
    logic [127:0] w, x, y;
    longint e;
    bit neg;
    at = magnitude(thr);
    sq = at * at;
    x = sq;
    y = cov_est;
    w = x * y;
    term = shift_sat(w, 32, 64'h4000_0000_0000_0000);
    d = (reg_forget << 8) + term;
    if (d == 0) d = 1;
    x = at;
    w = (x * y) << 8;
    kmag = div_sat(w, d, tmre_pkg::K_CAP);
    pnew = div_sat(y << 24, d, tmre_pkg::COV_MAX);
    e = a * 65536 - thr * gain_est;
    emag = magnitude(e);
    neg = (e < 0) != (thr < 0);
    x = kmag;
    y = emag;
    w = x * y;
    dmag = shift_sat(w, 40, {30'd0, tmre_pkg::DMAG_CAP});
    gain_est = clamp_s32(gain_est + (neg ? -longint'(dmag) : longint'(dmag)));
    cov_est = pnew;
  endfunction

  function automatic result_t estimate_step(item_t it);
    result_t r;
    longint a, thr;
    logic [31:0] age;
    int unsigned slot, h;
    a = longint'($signed(it.accel));
    thr = 0;
    r.updated = 1'b0;
    case (it.func)
      tmre_pkg::FUNC_CMD: begin
        thr = command_throttle(a);
        if (hist_count >= tmre_pkg::QUEUE_DEPTH) begin
          hist_head = (hist_head + 1) % tmre_pkg::QUEUE_DEPTH;
          hist_count = tmre_pkg::QUEUE_DEPTH - 1;
        end
        slot = (hist_head + hist_count) % tmre_pkg::QUEUE_DEPTH;
        hist_time[slot] = it.stamp;
        hist_thr[slot] = thr[31:0];
        hist_count++;
      end
      tmre_pkg::FUNC_MEAS: begin
        while (hist_count > 0) begin
          h = hist_head;
          age = it.stamp - hist_time[h];
          hist_head = (h + 1) % tmre_pkg::QUEUE_DEPTH;
          if (age > tmre_pkg::MAX_AGE_US) begin
            hist_count--;
            continue;
          end
          if (age < tmre_pkg::MIN_AGE_US) begin
            hist_head = h;
            break;
          end
          hist_count--;
          rls_update(longint'($signed(hist_thr[h])), a);
          r.updated = 1'b1;
          break;
        end
      end
      tmre_pkg::FUNC_REINIT: reseed_gain();
      default: ;
    endcase
    r.throttle = thr[31:0];
    r.gain = gain_est[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 200);
  endfunction

  function automatic logic [31:0] pick_accel();
    longint v;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: begin
        v = longint'($urandom_range(0, 60 * 65536)) - 30 * 65536;
        return v[31:0];
      end
    endcase
  endfunction

  task automatic add_item(logic [1:0] func, logic [31:0] accel, logic [31:0] stamp);
    pending_items.push_back('{func: func, accel: accel, stamp: stamp});
  endtask

  task automatic add_random(int n, int cmd_pct);
    int r;
    logic [1:0] f;
    repeat (n) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 99)) inside
        [0:3]:   now_us = $urandom;
        [4:6]:   now_us = now_us - 32'd10000;
        default: now_us = now_us + $urandom_range(500, 6000);
      endcase
      if (r < cmd_pct) f = tmre_pkg::FUNC_CMD;
      else if (r < 94) f = tmre_pkg::FUNC_MEAS;
      else if (r < 97) f = tmre_pkg::FUNC_REINIT;
      else f = FUNC_SPARE;
      add_item(f, pick_accel(), now_us);
    end
  endtask

  // Poll at the falling edge, where the driver and monitor updates have settled.
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_items.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      tmre_pkg::CFG_GRAVITY: reg_gravity = data & 32'h7FFF_FFFF;
      tmre_pkg::CFG_HOVER:   reg_hover = data & 32'h0001_FFFF;
      tmre_pkg::CFG_FORGET:  reg_forget = data & 32'h0001_FFFF;
      default: ;
    endcase
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("tb_thrust_model_rls_estimator_top NOT OK");
    $finish;
  end

  // Sender: offer queued items, with random gaps between words unless sender_eager is set.
  int gap_left;
  item_t cur_item;
  always @(posedge clk_i or negedge rst_ni) begin
    int g;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.func <= tmre_pkg::FUNC_CMD;
      in_if.accel_z <= '0;
      in_if.time_us <= '0;
      gap_left <= 0;
    end else begin
      g = gap_left;
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(estimate_step(cur_item));
        g = sender_eager ? 0 : pick_gap();
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the word until taken
      end else if (g == 0 && pending_items.size() != 0) begin
        cur_item = pending_items.pop_front();
        in_if.valid <= 1'b1;
        in_if.func <= cur_item.func;
        in_if.accel_z <= cur_item.accel;
        in_if.time_us <= cur_item.stamp;
        gap_left <= 0;
      end else begin
        in_if.valid <= 1'b0;
        gap_left <= (g > 0) ? g - 1 : 0;
      end
    end
  end

  // Receiver: check each result word, stall at random unless receiver_eager is set, once for a long stretch.
  int stall_left;
  bit long_stall_done;
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    int r;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
      long_stall_done <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("unexpected result word %0d", results_seen);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_if.throttle !== want.throttle)
            report_mismatch("throttle", out_if.throttle, want.throttle);
          if (out_if.model_updated !== want.updated)
            report_mismatch("model_updated", 32'(out_if.model_updated), 32'(want.updated));
          if (out_if.accel_per_throttle !== want.gain)
            report_mismatch("accel_per_throttle", out_if.accel_per_throttle, want.gain);
        end
      end
      if (!long_stall_done && results_seen >= 200) begin
        long_stall_done <= 1'b1;
        stall_left <= 3000;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        r = receiver_eager ? 0 : pick_gap();
        stall_left <= r;
        out_if.ready <= (r == 0);
      end
    end
  end

  initial begin
    error_count = 0;
    results_seen = 0;
    sender_eager = 1'b0;
    receiver_eager = 1'b0;
    hist_head = 0;
    hist_count = 0;
    reg_gravity = 64'(tmre_pkg::GRAVITY_RST);
    reg_hover = 64'(tmre_pkg::HOVER_RST);
    reg_forget = 64'(tmre_pkg::FF_RST);
    reseed_gain();
    cfg_if.valid = 1'b0;
    cfg_if.index = tmre_pkg::CFG_GRAVITY;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b0;
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, every func, stale and future entries, time wrap.
    add_item(tmre_pkg::FUNC_CMD, 32'd0, 32'd1000);
    add_item(tmre_pkg::FUNC_CMD, 32'h7FFF_FFFF, 32'd2000);
    add_item(tmre_pkg::FUNC_CMD, 32'h8000_0000, 32'd3000);
    add_item(FUNC_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(tmre_pkg::FUNC_MEAS, 32'd65536, 32'd4000);
    add_item(tmre_pkg::FUNC_MEAS, 32'h0009_CE80, 32'd38000);
    add_item(tmre_pkg::FUNC_MEAS, 32'h8000_0000, 32'd46500);
    add_item(tmre_pkg::FUNC_MEAS, 32'h7FFF_FFFF, 32'd46600);
    add_item(tmre_pkg::FUNC_CMD, 32'd65536, 32'd50000);
    add_item(tmre_pkg::FUNC_MEAS, 32'd65536, 32'd40000);
    add_item(tmre_pkg::FUNC_REINIT, 32'd0, 32'd41000);
    add_item(tmre_pkg::FUNC_CMD, 32'd65536, 32'd60000);
    add_item(tmre_pkg::FUNC_CMD, 32'hFFFB_0000, 32'd61000);
    add_item(tmre_pkg::FUNC_MEAS, 32'h000A_0000, 32'd96000);
    add_item(tmre_pkg::FUNC_MEAS, 32'hFFF6_0000, 32'd97000);
    add_item(tmre_pkg::FUNC_CMD, 32'h0014_0000, 32'hFFFF_F000);
    add_item(tmre_pkg::FUNC_MEAS, 32'h0009_0000, 32'd31904);
    add_item(tmre_pkg::FUNC_MEAS, 32'd0, 32'd32000);
    now_us = 32'd40000;
    add_random(180, 45);
    wait_idle();

    // Zero gain, then a zero denominator with a zero throttle entry.
    write_reg(tmre_pkg::CFG_GRAVITY, 32'd0);
    write_reg(tmre_pkg::CFG_FORGET, 32'd0);
    add_item(tmre_pkg::FUNC_REINIT, 32'd0, now_us);
    add_item(tmre_pkg::FUNC_CMD, 32'd0, now_us);
    add_item(tmre_pkg::FUNC_CMD, 32'h0001_0000, now_us + 32'd10);
    add_item(tmre_pkg::FUNC_CMD, 32'hFFFF_0000, now_us + 32'd20);
    add_item(tmre_pkg::FUNC_MEAS, 32'h0002_0000, now_us + 32'd36000);
    add_item(tmre_pkg::FUNC_MEAS, 32'h0002_0000, now_us + 32'd36010);
    now_us = now_us + 32'd40000;
    add_random(40, 45);
    wait_idle();

    // Largest gravity over full-scale hover, smallest forgetting factor.
    write_reg(tmre_pkg::CFG_GRAVITY, 32'h7FFF_FFFF);
    write_reg(tmre_pkg::CFG_HOVER, 32'h0001_0000);
    write_reg(tmre_pkg::CFG_FORGET, 32'd1);
    add_item(tmre_pkg::FUNC_REINIT, 32'd0, now_us);
    add_random(80, 45);
    wait_idle();

    // Saturated seed from the smallest hover throttle, full forgetting factor.
    write_reg(tmre_pkg::CFG_HOVER, 32'd1);
    write_reg(tmre_pkg::CFG_FORGET, 32'h0001_0000);
    add_item(tmre_pkg::FUNC_REINIT, 32'd0, now_us);
    add_random(80, 45);
    wait_idle();

    // Masked writes: hover becomes zero, unused index is ignored.
    write_reg(tmre_pkg::CFG_HOVER, 32'hFFFE_0000);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    write_reg(tmre_pkg::CFG_GRAVITY, 32'hFFFF_FFFF);
    add_item(tmre_pkg::FUNC_REINIT, 32'd0, now_us);
    sender_eager = 1'b1;
    receiver_eager = 1'b1;
    add_random(40, 45);
    wait_idle();
    sender_eager = 1'b0;
    receiver_eager = 1'b0;

    // Near defaults: overfill the queue, then regular traffic.
    write_reg(tmre_pkg::CFG_GRAVITY, 32'(tmre_pkg::GRAVITY_RST) + ($urandom & 32'hFFFF));
    write_reg(tmre_pkg::CFG_HOVER, 32'(tmre_pkg::HOVER_RST));
    write_reg(tmre_pkg::CFG_FORGET, 32'(tmre_pkg::FF_RST));
    add_item(tmre_pkg::FUNC_REINIT, 32'd0, now_us);
    repeat (110) begin
      now_us = now_us + 32'd300;
      add_item(tmre_pkg::FUNC_CMD, pick_accel(), now_us);
    end
    repeat (30) begin
      now_us = now_us + $urandom_range(500, 2000);
      add_item(tmre_pkg::FUNC_MEAS, pick_accel(), now_us);
    end
    add_random(200, 50);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0d result words never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0)
      $display("tb_thrust_model_rls_estimator_top OK");
    else
      $display("tb_thrust_model_rls_estimator_top NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
